// ===== design/bfd_pkg.sv =====
// Shared types and constants for the binary frame deframer.
`default_nettype none
package bfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register indexes on the configuration port (byte address bit 2)
    localparam logic REG_MAX_TYPE = 1'b0;
    localparam logic REG_MAX_LEN  = 1'b1;

    localparam logic [HALF_W-1:0] MAX_TYPE_RST = 16'd99;
    localparam logic [HALF_W-1:0] MAX_LEN_RST  = 16'd304;

    // Frame outcome codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_CKSUM    = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // "$BIN"
    localparam logic [BYTE_W-1:0] SYNC_WORD [4] = '{8'h24, 8'h42, 8'h49, 8'h4E};

    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [HALF_W-1:0] block_type;
        logic [HALF_W-1:0] block_len;
        logic [1:0]        frame_status;
    } bfd_result_t;

    typedef struct packed {
        logic [HALF_W-1:0] max_block_type;
        logic [HALF_W-1:0] max_payload_len;
    } bfd_limits_t;

endpackage
`default_nettype wire

// ===== design/bfd_cfg_regs.sv =====
// APB limit registers for the deframer header check.
`default_nettype none
module bfd_cfg_regs
    import bfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output bfd_limits_t            limits
);

    logic [HALF_W-1:0] max_type_reg;
    logic [HALF_W-1:0] max_len_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_type_reg <= MAX_TYPE_RST;
            max_len_reg  <= MAX_LEN_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MAX_TYPE)
                max_type_reg <= pwdata[HALF_W-1:0];
            else
                max_len_reg <= pwdata[HALF_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_TYPE)
            prdata[HALF_W-1:0] = max_type_reg;
        else
            prdata[HALF_W-1:0] = max_len_reg;
    end

    assign limits.max_block_type  = max_type_reg;
    assign limits.max_payload_len = max_len_reg;

endmodule
`default_nettype wire

// ===== design/bfd_parser.sv =====
// Frame parser state machine: one received byte per accepted transaction.
`default_nettype none
module bfd_parser
    import bfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire bfd_limits_t       limits,
    output logic                   res_valid,
    output bfd_result_t            res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CKSUM   = 3'd4;
    localparam logic [2:0] PH_TRAILER = 3'd5;
    localparam logic [2:0] PH_TRUNC   = 3'd6;

    typedef struct packed {
        logic       hit;
        logic [1:0] cnt;
    } sync_step_t;

    // One byte of a "$BIN" matcher; a '$' on mismatch restarts at one
    function automatic sync_step_t sync_step(input logic [1:0] cnt, input logic [7:0] b);
        sync_step_t r;
        r.hit = 1'b0;
        r.cnt = 2'd0;
        if (b == SYNC_WORD[cnt])
        begin
            if (cnt == 2'd3)
                r.hit = 1'b1;
            else
                r.cnt = cnt + 2'd1;
        end
        else if (b == SYNC_WORD[0])
        begin
            r.cnt = 2'd1;
        end
        return r;
    endfunction

    logic [2:0]        phase_reg,   phase_next;
    logic [1:0]        sync_reg,    sync_next;
    logic              idx_reg,     idx_next;
    logic [HALF_W-1:0] type_reg,    type_next;
    logic [HALF_W-1:0] len_reg,     len_next;
    logic [HALF_W-1:0] remain_reg,  remain_next;
    logic [HALF_W-1:0] sum_reg,     sum_next;
    logic [HALF_W-1:0] cksum_reg,   cksum_next;
    logic [1:0]        inner_reg,   inner_next;
    logic              trunc_reg,   trunc_next;

    logic [HALF_W-1:0] len_full;
    sync_step_t        hunt_s;
    sync_step_t        inner_s;
    logic              emit;
    logic              emit_kind;
    logic [BYTE_W-1:0] emit_byte;
    logic [1:0]        emit_status;

    assign len_full = {rx_byte, len_reg[BYTE_W-1:0]};
    assign inner_s  = sync_step(inner_reg, rx_byte);

    always_comb
    begin
        phase_next  = phase_reg;
        sync_next   = sync_reg;
        idx_next    = idx_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        cksum_next  = cksum_reg;
        inner_next  = inner_reg;
        trunc_next  = trunc_reg;
        emit        = 1'b0;
        emit_kind   = KIND_REPORT;
        emit_byte   = '0;
        emit_status = ST_OK;
        hunt_s      = sync_step(sync_reg, rx_byte);

        case (phase_reg)
            PH_TYPE:
            begin
                if (!idx_reg)
                begin
                    type_next = {8'h00, rx_byte};
                    idx_next  = 1'b1;
                end
                else
                begin
                    type_next  = {rx_byte, type_reg[BYTE_W-1:0]};
                    idx_next   = 1'b0;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (!idx_reg)
                begin
                    len_next = {8'h00, rx_byte};
                    idx_next = 1'b1;
                end
                else
                begin
                    len_next = len_full;
                    idx_next = 1'b0;
                    if (type_reg > limits.max_block_type || len_full > limits.max_payload_len)
                    begin
                        phase_next  = PH_HUNT;
                        emit        = 1'b1;
                        emit_status = ST_BAD_HDR;
                    end
                    else
                    begin
                        sum_next    = '0;
                        cksum_next  = '0;
                        inner_next  = 2'd0;
                        trunc_next  = 1'b0;
                        remain_next = len_full;
                        phase_next  = (len_full == '0) ? PH_CKSUM : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                sum_next    = sum_reg + {8'h00, rx_byte};
                inner_next  = inner_s.cnt;
                trunc_next  = trunc_reg | inner_s.hit;
                remain_next = remain_reg - 16'd1;
                if (remain_next == '0)
                    phase_next = trunc_next ? PH_TRUNC : PH_CKSUM;
                emit      = 1'b1;
                emit_kind = KIND_PAYLOAD;
                emit_byte = rx_byte;
            end
            PH_CKSUM:
            begin
                if (!idx_reg)
                begin
                    cksum_next = {8'h00, rx_byte};
                    idx_next   = 1'b1;
                end
                else
                begin
                    cksum_next = {rx_byte, cksum_reg[BYTE_W-1:0]};
                    idx_next   = 1'b0;
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (!idx_reg)
                begin
                    idx_next = 1'b1;
                end
                else
                begin
                    idx_next    = 1'b0;
                    phase_next  = PH_HUNT;
                    emit        = 1'b1;
                    emit_status = (sum_reg == cksum_reg) ? ST_OK : ST_CKSUM;
                end
            end
            default:
            begin
                // truncation report: the byte after the payload restarts the hunt
                if (phase_reg == PH_TRUNC)
                begin
                    hunt_s      = sync_step(2'd0, rx_byte);
                    emit        = 1'b1;
                    emit_status = ST_TRUNC;
                end
                phase_next = PH_HUNT;
                sync_next  = hunt_s.cnt;
                if (hunt_s.hit)
                begin
                    idx_next   = 1'b0;
                    type_next  = '0;
                    len_next   = '0;
                    phase_next = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            sync_reg   <= 2'd0;
            idx_reg    <= 1'b0;
            type_reg   <= '0;
            len_reg    <= '0;
            remain_reg <= '0;
            sum_reg    <= '0;
            cksum_reg  <= '0;
            inner_reg  <= 2'd0;
            trunc_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            sync_reg   <= sync_next;
            idx_reg    <= idx_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            sum_reg    <= sum_next;
            cksum_reg  <= cksum_next;
            inner_reg  <= inner_next;
            trunc_reg  <= trunc_next;
        end
    end

    assign res_valid        = fire && emit;
    assign res.item_kind    = emit_kind;
    assign res.payload_byte = emit_byte;
    assign res.block_type   = type_next;
    assign res.block_len    = len_next;
    assign res.frame_status = emit_status;

`ifndef SYNTHESIS
    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 3'd7)
        else $error("parser phase left the code set");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with nothing left to take");

    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_PAYLOAD |-> res_valid && res.item_kind == KIND_PAYLOAD)
        else $error("payload byte not passed on");

    a_trunc_next: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRUNC |-> trunc_reg)
        else $error("truncation phase without embedded sync");
`endif

endmodule
`default_nettype wire

// ===== design/bfd_out_reg.sv =====
// Result register between the parser and the output channel.
`default_nettype none
module bfd_out_reg
    import bfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire bfd_result_t res,
    input  wire logic        out_stall,
    output logic             out_valid,
    output bfd_result_t      out_res
);

    logic        valid_reg, valid_next;
    bfd_result_t data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule
`default_nettype wire

// ===== design/bin_frame_deframer.sv =====
// Top level of the "$BIN" binary frame deframer.
// Takes one received byte per transaction and can take one every clock cycle;
// each byte passes through the parser logic in the cycle it is accepted and any
// result is captured by the output register at that cycle's end. Input is stalled
// only while a result is held in the output register and the output side stalls.
// Results are payload bytes (item_kind 0) and frame outcome reports (item_kind 1)
// carrying the header type, length and status. The two header limits sit at
// byte addresses 0 and 4 on the APB port and should be written while idle.
`default_nettype none
module bin_frame_deframer
    import bfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   item_kind,
    output logic      [BYTE_W-1:0] payload_byte,
    output logic      [HALF_W-1:0] block_type,
    output logic      [HALF_W-1:0] block_len,
    output logic      [1:0]        frame_status,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    bfd_limits_t limits;
    bfd_result_t res;
    bfd_result_t out_res;
    logic        res_valid;
    logic        fire;

    assign in_stall = out_valid && out_stall;
    assign fire     = in_valid && !in_stall;

    bfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    bfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rx_byte   (rx_byte),
        .limits    (limits),
        .res_valid (res_valid),
        .res       (res)
    );

    bfd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign item_kind    = out_res.item_kind;
    assign payload_byte = out_res.payload_byte;
    assign block_type   = out_res.block_type;
    assign block_len    = out_res.block_len;
    assign frame_status = out_res.frame_status;

endmodule
`default_nettype wire

// ===== verif/bin_frame_deframer_tb.sv =====
// Testbench for bin_frame_deframer: directed and random byte streams checked by a frame predictor.
`timescale 1ns / 100ps
module bin_frame_deframer_tb;
    import bfd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_MAX   = 10;
    localparam int SETTLE      = 4;
    localparam int DIR_ROWS    = 33;

    typedef enum logic [2:0] {
        PH_HUNT, PH_TYPE, PH_LEN, PH_BODY, PH_CKSUM, PH_TRAILER, PH_TRUNC
    } parse_phase_e;

    typedef struct packed {
        logic [7:0]  b;
        logic        pinned;
        bfd_result_t res;
    } stim_row_t;

    localparam bfd_result_t NONE = '0;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_stall = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    wire               in_stall;
    wire               out_valid;
    wire               item_kind;
    wire  [BYTE_W-1:0] payload_byte;
    wire  [HALF_W-1:0] block_type;
    wire  [HALF_W-1:0] block_len;
    wire  [1:0]        frame_status;
    wire  [APB_DW-1:0] prdata;
    wire               pready;

    bin_frame_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_kind    (item_kind),
        .payload_byte (payload_byte),
        .block_type   (block_type),
        .block_len    (block_len),
        .frame_status (frame_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    // predictor state
    parse_phase_e ph;
    logic [1:0]   hunt_cnt;
    logic [1:0]   inner_cnt;
    logic         fidx;
    logic [15:0]  hdr_type;
    logic [15:0]  hdr_len;
    logic [15:0]  remaining;
    logic [15:0]  body_sum;
    logic [15:0]  rx_sum;
    logic         trunc_seen;
    logic [15:0]  lim_type;
    logic [15:0]  lim_len;

    bfd_result_t frame_items_due [$];
    int          fail_count = 0;
    int          cycles     = 0;
    int          sent       = 0;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    stim_row_t   dir_rows [DIR_ROWS];

    // Advances a "$BIN" matcher by one byte; true when the fourth byte lands.
    function automatic bit sync_step(input logic [7:0] b, inout logic [1:0] cnt);
        if (b == SYNC_WORD[cnt]) begin
            if (cnt == 2'd3) begin
                cnt = 2'd0;
                return 1'b1;
            end
            cnt = cnt + 2'd1;
        end else begin
            cnt = (b == SYNC_WORD[0]) ? 2'd1 : 2'd0;
        end
        return 1'b0;
    endfunction

    function automatic bit deframe(input logic [7:0] b, output bfd_result_t res);
        bit got;
        bit to_hunt;
        got = 1'b0;
        to_hunt = 1'b0;
        res = '0;
        case (ph)
            PH_TYPE: begin
                if (!fidx) begin
                    hdr_type = {8'h00, b};
                    fidx = 1'b1;
                end else begin
                    hdr_type[15:8] = b;
                    fidx = 1'b0;
                    ph = PH_LEN;
                end
            end
            PH_LEN: begin
                if (!fidx) begin
                    hdr_len = {8'h00, b};
                    fidx = 1'b1;
                end else begin
                    hdr_len[15:8] = b;
                    fidx = 1'b0;
                    if (hdr_type > lim_type || hdr_len > lim_len) begin
                        ph = PH_HUNT;
                        got = 1'b1;
                        res = {KIND_REPORT, 8'h00, hdr_type, hdr_len, ST_BAD_HDR};
                    end else begin
                        body_sum = '0;
                        rx_sum = '0;
                        inner_cnt = '0;
                        trunc_seen = 1'b0;
                        remaining = hdr_len;
                        ph = (hdr_len == 16'd0) ? PH_CKSUM : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                body_sum = body_sum + {8'h00, b};
                if (sync_step(b, inner_cnt))
                    trunc_seen = 1'b1;
                remaining = remaining - 16'd1;
                if (remaining == 16'd0)
                    ph = trunc_seen ? PH_TRUNC : PH_CKSUM;
                got = 1'b1;
                res = {KIND_PAYLOAD, b, hdr_type, hdr_len, ST_OK};
            end
            PH_CKSUM: begin
                if (!fidx) begin
                    rx_sum = {8'h00, b};
                    fidx = 1'b1;
                end else begin
                    rx_sum[15:8] = b;
                    fidx = 1'b0;
                    ph = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                if (!fidx) begin
                    fidx = 1'b1;
                end else begin
                    fidx = 1'b0;
                    ph = PH_HUNT;
                    got = 1'b1;
                    res = {KIND_REPORT, 8'h00, hdr_type, hdr_len,
                           (body_sum == rx_sum) ? ST_OK : ST_CKSUM};
                end
            end
            PH_TRUNC: begin
                // report rides on the byte after the frame, which also feeds the hunt
                hunt_cnt = '0;
                got = 1'b1;
                res = {KIND_REPORT, 8'h00, hdr_type, hdr_len, ST_TRUNC};
                to_hunt = 1'b1;
            end
            default: to_hunt = 1'b1;
        endcase
        if (to_hunt) begin
            ph = PH_HUNT;
            if (sync_step(b, hunt_cnt)) begin
                fidx = 1'b0;
                hdr_type = '0;
                hdr_len = '0;
                ph = PH_TYPE;
            end
        end
        return got;
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit pinned = 1'b0,
                             input bfd_result_t pin_res = '0);
        bfd_result_t res;
        bit got;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        got = deframe(b, res);
        if (pinned)
            frame_items_due.push_back(pin_res);
        else if (got)
            frame_items_due.push_back(res);
        sent++;
    endtask

    // Let every owed result out, then give header-only bytes time to settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (frame_items_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // read the register straight back
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'h0000, val}) begin
            if (fail_count < SHOWN_MAX)
                $display("register read exp=%08h got=%08h", {16'h0000, val}, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MAX_TYPE)
            lim_type = val;
        else
            lim_len = val;
    endtask

    task automatic send_frame();
        int n;
        int cap;
        int at;
        int pick;
        logic [15:0] ftype;
        logic [15:0] flen;
        logic [15:0] ck;
        logic [7:0]  body [$];
        pick = $urandom_range(99);
        // line noise with stray sync characters; some of it stands alone
        if (pick < 12) begin
            n = $urandom_range(1, 6);
            repeat (n)
                push_byte($urandom_range(1) ? 8'($urandom()) : SYNC_WORD[$urandom_range(3)]);
            if (pick < 6)
                return;
        end
        foreach (SYNC_WORD[i])
            push_byte(SYNC_WORD[i]);
        pick = $urandom_range(99);
        ftype = 16'($urandom_range(0, lim_type));
        if ($urandom_range(7) == 0)
            ftype = lim_type;
        cap = ($urandom_range(9) == 0) ? 48 : 10;
        if (lim_len < cap)
            cap = int'(lim_len);
        flen = 16'($urandom_range(0, cap));
        if (pick < 8 && lim_type != 16'hFFFF)
            ftype = 16'($urandom_range(int'(lim_type) + 1, 65535));
        else if (pick < 16 && lim_len != 16'hFFFF)
            flen = 16'($urandom_range(int'(lim_len) + 1, 65535));
        push_byte(ftype[7:0]);
        push_byte(ftype[15:8]);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        if (ftype > lim_type || flen > lim_len)
            return;
        ck = '0;
        repeat (flen) body.push_back(8'($urandom()));
        if (flen >= 4 && $urandom_range(4) == 0) begin
            at = $urandom_range(1) ? int'(flen) - 4 : $urandom_range(0, int'(flen) - 4);
            foreach (SYNC_WORD[i])
                body[at + i] = SYNC_WORD[i];
        end
        foreach (body[i]) begin
            ck = ck + 16'(body[i]);
            push_byte(body[i]);
        end
        if ($urandom_range(3) == 0)
            ck = ck ^ 16'($urandom_range(1, 65535));
        push_byte(ck[7:0]);
        push_byte(ck[15:8]);
        push_byte(8'($urandom()));
        push_byte(8'($urandom()));
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int n);
        int target;
        idle_pct = send_idle;
        stall_pct = recv_stall;
        target = sent + n;
        while (sent < target) begin
            send_frame();
            if ($urandom_range(39) == 0)
                drain();
        end
        drain();
    endtask

    // receive side: random stall and compare against the oldest owed result
    always @(posedge clk) begin
        bfd_result_t got;
        bfd_result_t want;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            got = {item_kind, payload_byte, block_type, block_len, frame_status};
            if (frame_items_due.size() == 0) begin
                if (fail_count < SHOWN_MAX)
                    $display("unexpected result kind=%0d byte=%02h type=%04h len=%04h st=%0d",
                             got.item_kind, got.payload_byte, got.block_type,
                             got.block_len, got.frame_status);
                fail_count++;
            end else begin
                want = frame_items_due.pop_front();
                if (got.item_kind !== want.item_kind || got.payload_byte !== want.payload_byte
                    || got.block_type !== want.block_type || got.block_len !== want.block_len
                    || got.frame_status !== want.frame_status) begin
                    if (fail_count < SHOWN_MAX)
                        $display("mismatch exp kind=%0d byte=%02h type=%04h len=%04h st=%0d %s",
                                 want.item_kind, want.payload_byte, want.block_type,
                                 want.block_len, want.frame_status, "");
                    if (fail_count < SHOWN_MAX)
                        $display("         got kind=%0d byte=%02h type=%04h len=%04h st=%0d",
                                 got.item_kind, got.payload_byte, got.block_type,
                                 got.block_len, got.frame_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        ph = PH_HUNT;
        hunt_cnt = '0;
        inner_cnt = '0;
        fidx = 1'b0;
        hdr_type = '0;
        hdr_len = '0;
        remaining = '0;
        body_sum = '0;
        rx_sum = '0;
        trunc_seen = 1'b0;
        lim_type = MAX_TYPE_RST;
        lim_len = MAX_LEN_RST;

        dir_rows = '{
            // bad header after a sync that restarts on a repeated '$'
            '{8'h24, 1'b0, NONE}, '{8'h24, 1'b0, NONE}, '{8'h42, 1'b0, NONE},
            '{8'h49, 1'b0, NONE}, '{8'h4E, 1'b0, NONE},
            '{8'hFF, 1'b0, NONE}, '{8'hFF, 1'b0, NONE},
            '{8'h00, 1'b0, NONE},
            '{8'h00, 1'b1, {KIND_REPORT, 8'h00, 16'hFFFF, 16'h0000, ST_BAD_HDR}},
            // four-byte payload that is itself "$BIN": truncated
            '{8'h24, 1'b0, NONE}, '{8'h42, 1'b0, NONE}, '{8'h49, 1'b0, NONE},
            '{8'h4E, 1'b0, NONE},
            '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
            '{8'h04, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
            '{8'h24, 1'b1, {KIND_PAYLOAD, 8'h24, 16'h0000, 16'h0004, ST_OK}},
            '{8'h42, 1'b1, {KIND_PAYLOAD, 8'h42, 16'h0000, 16'h0004, ST_OK}},
            '{8'h49, 1'b1, {KIND_PAYLOAD, 8'h49, 16'h0000, 16'h0004, ST_OK}},
            '{8'h4E, 1'b1, {KIND_PAYLOAD, 8'h4E, 16'h0000, 16'h0004, ST_OK}},
            // report byte is the first sync byte of the next frame
            '{8'h24, 1'b1, {KIND_REPORT, 8'h00, 16'h0000, 16'h0004, ST_TRUNC}},
            '{8'h42, 1'b0, NONE}, '{8'h49, 1'b0, NONE}, '{8'h4E, 1'b0, NONE},
            // largest type, zero length, wrong checksum
            '{8'h63, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
            '{8'h00, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
            '{8'hFF, 1'b0, NONE}, '{8'hFF, 1'b0, NONE},
            '{8'h00, 1'b0, NONE},
            '{8'hFF, 1'b1, {KIND_REPORT, 8'h00, 16'h0063, 16'h0000, ST_CKSUM}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_byte(dir_rows[i].b, dir_rows[i].pinned, dir_rows[i].res);
        drain();

        run_phase(0, 0, 90);
        cfg_write(REG_MAX_TYPE, 16'd0);
        cfg_write(REG_MAX_LEN, 16'd0);
        run_phase(59, 0, 90);
        cfg_write(REG_MAX_TYPE, 16'hFFFF);
        cfg_write(REG_MAX_LEN, 16'hFFFF);
        run_phase(0, 59, 90);
        cfg_write(REG_MAX_TYPE, 16'($urandom_range(0, 300)));
        cfg_write(REG_MAX_LEN, 16'($urandom_range(0, 60)));
        run_phase(10, 10, 90);
        cfg_write(REG_MAX_TYPE, 16'd0);
        cfg_write(REG_MAX_LEN, 16'hFFFF);
        run_phase(0, 0, 90);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/bfd_pkg.sv
design/bfd_cfg_regs.sv
design/bfd_parser.sv
design/bfd_out_reg.sv
design/bin_frame_deframer.sv
verif/bin_frame_deframer_tb.sv
